// ===== rtl/tbpe_pkg.sv =====
`timescale 1ns / 1ps

package tbpe_pkg;

    // Request codes on s_req_type.
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_GAP     = 2'd1;
    localparam logic [1:0] REQ_SILENCE = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_FAST = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    localparam logic [7:0] HIGH_LEVEL_RESET = 8'd192;
    localparam logic [7:0] LEVEL_MAX        = 8'd255;
    localparam logic [7:0] SILENCE_LEVEL    = 8'h80;
    localparam logic [4:0] SILENCE_LENGTH   = 5'd1;

    // Index of the final run of each request kind.
    localparam logic [4:0] LAST_IDX_NORMAL = 5'd27;
    localparam logic [4:0] LAST_IDX_FAST   = 5'd25;
    localparam logic [4:0] LAST_IDX_GAP    = 5'd1;

    // Bit positions inside a byte frame.
    localparam logic [3:0] BIT_START  = 4'd0;
    localparam logic [3:0] BIT_PARITY = 4'd9;

    // Run lengths indexed by {rate, fast, bit value, second run}.
    localparam logic [4:0] RUN_TABLE [0:31] = '{
        5'd1, 5'd2,  5'd1, 5'd1,  5'd1, 5'd2,  5'd1, 5'd1,
        5'd2, 5'd3,  5'd2, 5'd1,  5'd1, 5'd4,  5'd1, 5'd1,
        5'd2, 5'd5,  5'd2, 5'd2,  5'd1, 5'd5,  5'd1, 5'd1,
        5'd6, 5'd22, 5'd6, 5'd6,  5'd3, 5'd21, 5'd3, 5'd3
    };

    typedef struct packed {
        logic [1:0] rate_select;
        logic       fast_mode;
        logic [7:0] high_level;
    } cfg_t;

    typedef struct packed {
        logic [7:0] level;
        logic [4:0] run_length;
        logic       last;
        logic       flip;
    } run_t;

endpackage

// ===== rtl/tbpe_run_gen.sv =====
`timescale 1ns / 1ps

module tbpe_run_gen (
    input  tbpe_pkg::cfg_t cfg,
    input  logic [1:0]     req_type,
    input  logic [7:0]     data_byte,
    input  logic [4:0]     run_idx,
    input  logic           level_phase,
    output tbpe_pkg::run_t run
);
    import tbpe_pkg::*;

    logic [3:0] bit_num;
    logic [3:0] data_pos;
    logic       bit_value;
    logic       new_phase;

    assign bit_num  = run_idx[4:1];
    assign data_pos = bit_num - 4'd1;

    // Bit value for the current run; a gap is a single 1 bit.
    always_comb begin
        if (req_type == REQ_GAP) begin
            bit_value = 1'b1;
        end else if (bit_num == BIT_START) begin
            bit_value = 1'b0;
        end else if (bit_num < BIT_PARITY) begin
            bit_value = data_byte[data_pos[2:0]];
        end else if (bit_num == BIT_PARITY) begin
            // Odd parity over data plus parity bit.
            bit_value = ~(^data_byte);
        end else begin
            bit_value = 1'b1;
        end
    end

    assign new_phase = ~level_phase;

    always_comb begin
        run.flip       = 1'b1;
        run.level      = new_phase ? cfg.high_level : (LEVEL_MAX - cfg.high_level);
        run.run_length = RUN_TABLE[{cfg.rate_select, cfg.fast_mode, bit_value, run_idx[0]}];
        case (req_type)
            REQ_SILENCE: begin
                run.flip       = 1'b0;
                run.level      = SILENCE_LEVEL;
                run.run_length = SILENCE_LENGTH;
                run.last       = 1'b1;
            end
            REQ_GAP: begin
                run.last = (run_idx == LAST_IDX_GAP);
            end
            default: begin
                run.last = cfg.fast_mode ? (run_idx == LAST_IDX_FAST)
                                         : (run_idx == LAST_IDX_NORMAL);
            end
        endcase
    end

endmodule

// ===== rtl/tape_byte_pulse_encoder_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// request  | s_valid, s_ready, s_req_type, s_data_byte      | in
// runs     | m_valid, m_ready, m_level, m_run_length,       | out
//          | m_last_of_run                                  |
// config   | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//          | pready                                         |
//
// One run leaves the run generator per cycle unless m_ready stalls the output.
// A data byte gives 28 runs (26 in fast mode), a gap 2 runs, a silence request
// 1 run, and an unknown request is taken and gives no run.
// The next request is taken in the cycle that the final run of the current one
// is loaded into the result register, so requests follow without a gap.
// A stall on m_ready holds the result register and the run counter.
// Reset is synchronous on aresetn and restores the register defaults and a
// high current level, so the first run after reset is at the low level.

module tape_byte_pulse_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_level,
    output logic [4:0]  m_run_length,
    output logic        m_last_of_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tbpe_pkg::*;

    cfg_t       cfg_reg;
    logic       item_valid_reg;
    logic [1:0] req_reg;
    logic [7:0] byte_reg;
    logic [4:0] idx_reg;
    logic       phase_reg;
    logic       m_valid_reg;
    logic [7:0] m_level_reg;
    logic [4:0] m_run_length_reg;
    logic       m_last_reg;

    run_t       run;
    logic       advance;
    logic       s_transfer;
    logic       cfg_write;

    tbpe_run_gen u_run_gen (
        .cfg         (cfg_reg),
        .req_type    (req_reg),
        .data_byte   (byte_reg),
        .run_idx     (idx_reg),
        .level_phase (phase_reg),
        .run         (run)
    );

    assign advance    = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !item_valid_reg || (advance && run.last);
    assign s_transfer = s_valid && s_ready;
    assign cfg_write  = psel && penable && pwrite;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_RATE: prdata = {30'd0, cfg_reg.rate_select};
            REG_FAST: prdata = {31'd0, cfg_reg.fast_mode};
            REG_HIGH: prdata = {24'd0, cfg_reg.high_level};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_select <= 2'd0;
            cfg_reg.fast_mode   <= 1'b0;
            cfg_reg.high_level  <= HIGH_LEVEL_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_RATE: cfg_reg.rate_select <= pwdata[1:0];
                REG_FAST: cfg_reg.fast_mode   <= pwdata[0];
                REG_HIGH: cfg_reg.high_level  <= pwdata[7:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 5'd0;
            phase_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_transfer) begin
                // An unknown request type is taken and dropped here.
                item_valid_reg <= (s_req_type != REQ_NONE);
                idx_reg        <= 5'd0;
            end else if (advance) begin
                if (run.last) begin
                    item_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 5'd1;
            end

            if (advance && run.flip) begin
                phase_reg <= ~phase_reg;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            req_reg  <= s_req_type;
            byte_reg <= s_data_byte;
        end
        if (advance) begin
            m_level_reg      <= run.level;
            m_run_length_reg <= run.run_length;
            m_last_reg       <= run.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_level       = m_level_reg;
    assign m_run_length  = m_run_length_reg;
    assign m_last_of_run = m_last_reg;

`ifndef SYNTHESIS
    a_idx_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> (idx_reg <= LAST_IDX_NORMAL))
        else $error("run index beyond the end of a byte frame");

    a_accept_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_transfer && item_valid_reg) |-> (advance && run.last))
        else $error("new request taken before the final run of the current one");

    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_transfer |=> (idx_reg == 5'd0))
        else $error("run index did not restart on a new request");

    a_silence_keeps_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (req_reg == REQ_SILENCE)) |=> $stable(phase_reg))
        else $error("level phase changed on a silence sample");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tbpe_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RUN_PHASES   = 5;
    localparam int PHASE_ITEMS  = 16;

    // Register index that decodes to no register.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Receiver behaviors.
    localparam int RX_READY    = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    typedef struct {
        logic [7:0] level;
        logic [4:0] run_length;
        logic       last;
    } pulse_run_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type  = REQ_BYTE;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_level;
    logic [4:0]  m_run_length;
    logic        m_last_of_run;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the encoder state and its registers.
    logic [1:0]  cur_rate  = 2'd0;
    logic        cur_fast  = 1'b0;
    logic [7:0]  cur_high  = HIGH_LEVEL_RESET;
    logic        cur_phase = 1'b1;
    pulse_run_t  runs_due[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int gap_max        = 3;
    int burst_left     = 0;
    int rx_mode        = RX_RANDOM;
    int stall_pct      = 30;
    int hold_left      = 0;
    int rx_tick        = 0;
    bit hold_req       = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    tape_byte_pulse_encoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_run_length  (m_run_length),
        .m_last_of_run (m_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic logic [4:0] pulse_len(logic bit_val, logic second);
        logic [4:0] head;
        logic [4:0] tail_one;
        logic [4:0] tail_zero;
        case ({cur_rate, cur_fast})
            3'b000, 3'b001: begin head = 5'd1; tail_one = 5'd1; tail_zero = 5'd2;  end
            3'b010:         begin head = 5'd2; tail_one = 5'd1; tail_zero = 5'd3;  end
            3'b011:         begin head = 5'd1; tail_one = 5'd1; tail_zero = 5'd4;  end
            3'b100:         begin head = 5'd2; tail_one = 5'd2; tail_zero = 5'd5;  end
            3'b101:         begin head = 5'd1; tail_one = 5'd1; tail_zero = 5'd5;  end
            3'b110:         begin head = 5'd6; tail_one = 5'd6; tail_zero = 5'd22; end
            default:        begin head = 5'd3; tail_one = 5'd3; tail_zero = 5'd21; end
        endcase
        if (!second)
            return head;
        return bit_val ? tail_one : tail_zero;
    endfunction

    // The level flips before every run and is taken from the present high level.
    function automatic void add_run(logic [4:0] len);
        pulse_run_t r;
        cur_phase    = ~cur_phase;
        r.level      = cur_phase ? cur_high : LEVEL_MAX - cur_high;
        r.run_length = len;
        r.last       = 1'b0;
        runs_due.push_back(r);
    endfunction

    function automatic void add_bit(logic bit_val);
        add_run(pulse_len(bit_val, 1'b0));
        add_run(pulse_len(bit_val, 1'b1));
    endfunction

    function automatic void predict_runs(logic [1:0] req, logic [7:0] data);
        pulse_run_t r;
        int i;
        case (req)
            REQ_BYTE: begin
                add_bit(1'b0);
                for (i = 0; i < 8; i++)
                    add_bit(data[i]);
                add_bit(~^data);
                for (i = 0; i < (cur_fast ? 3 : 4); i++)
                    add_bit(1'b1);
            end
            REQ_GAP: begin
                add_bit(1'b1);
            end
            REQ_SILENCE: begin
                r.level      = SILENCE_LEVEL;
                r.run_length = SILENCE_LENGTH;
                r.last       = 1'b0;
                runs_due.push_back(r);
            end
            default: begin
                return;
            end
        endcase
        r = runs_due.pop_back();
        r.last = 1'b1;
        runs_due.push_back(r);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_READY:    m_ready <= 1'b1;
                RX_RANDOM:   m_ready <= ($urandom_range(99) >= stall_pct);
                RX_PERIODIC: m_ready <= ((rx_tick % 9) < 5);
                default:     m_ready <= 1'b1;
            endcase
        end
        rx_tick++;
    end

    always @(posedge aclk) begin : check_runs
        pulse_run_t want;
        if (aresetn && m_valid && m_ready) begin
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run: level %0d length %0d last %0b",
                         $time, m_level, m_run_length, m_last_of_run);
                mismatch_count++;
            end else begin
                want = runs_due.pop_front();
                if (m_level !== want.level) begin
                    $display("%0t: level expected %0d actual %0d",
                             $time, want.level, m_level);
                    mismatch_count++;
                end
                if (m_run_length !== want.run_length) begin
                    $display("%0t: run_length expected %0d actual %0d",
                             $time, want.run_length, m_run_length);
                    mismatch_count++;
                end
                if (m_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last, m_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("tape_byte_pulse_encoder_unit test failed");
        $finish;
    end

    // Holds the request until its transfer, then predicts the runs it causes.
    task automatic send_item(input logic [1:0] req, input logic [7:0] data);
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_runs(req, data);
    endtask

    task automatic offer(input logic [1:0] req, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        send_item(req, data);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (runs_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RATE: cur_rate = value[1:0];
            REG_FAST: cur_fast = value[0];
            REG_HIGH: cur_high = value[7:0];
            default:  ;
        endcase
        @(posedge aclk);
    endtask

    // Upper data bits are random; only the register's own bits may count.
    task automatic set_config(input logic [1:0] rate, input logic fast, input logic [7:0] high);
        drain();
        cfg_write(REG_RATE, ($urandom() & ~32'h3)  | rate);
        cfg_write(REG_FAST, ($urandom() & ~32'h1)  | fast);
        cfg_write(REG_HIGH, ($urandom() & ~32'hFF) | high);
    endtask

    function automatic logic [1:0] pick_request;
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return REQ_BYTE;
        if (roll < 85)
            return REQ_GAP;
        if (roll < 93)
            return REQ_SILENCE;
        return REQ_NONE;
    endfunction

    // Default registers after reset, every request kind and the data extremes.
    task automatic test_reset_defaults;
        offer(REQ_BYTE, 8'h00);
        offer(REQ_BYTE, 8'hFF);
        offer(REQ_GAP, 8'h00);
        offer(REQ_SILENCE, 8'h5A);
        offer(REQ_NONE, 8'hFF);
        offer(REQ_SILENCE, 8'h00);
        offer(REQ_BYTE, 8'hA5);
        offer(REQ_NONE, 8'h00);
        offer(REQ_GAP, 8'hFF);
        drain();
    endtask

    // The level phase carries over while the high level changes between items.
    task automatic test_level_change;
        cfg_write(REG_HIGH, 32'd255);
        offer(REQ_GAP, 8'h00);
        offer(REQ_BYTE, 8'h01);
        drain();
        cfg_write(REG_HIGH, 32'd128);
        offer(REQ_BYTE, 8'h80);
        drain();
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        offer(REQ_GAP, 8'h3C);
        drain();
    endtask

    // One byte per rate and speed, so every entry of the run table shows up.
    task automatic test_run_tables;
        int r;
        int f;
        for (r = 0; r < 4; r++) begin
            for (f = 0; f < 2; f++) begin
                set_config(r[1:0], f[0], 8'($urandom_range(255, 128)));
                offer(REQ_BYTE, 8'($urandom_range(255)));
            end
        end
        drain();
    endtask

    task automatic test_random_traffic;
        int ph;
        int n;
        for (ph = 0; ph < RUN_PHASES; ph++) begin
            if (ph == 0)
                set_config(2'd0, 1'b0, 8'd128);
            else if (ph == 1)
                set_config(2'd3, 1'b1, 8'd255);
            else
                set_config(2'($urandom_range(3)), 1'($urandom_range(1)),
                           8'($urandom_range(255, 128)));
            gap_max   = (ph == 2) ? 0 : $urandom_range(8, 1);
            rx_mode   = (ph == 2) ? RX_READY : ph % 3;
            stall_pct = $urandom_range(70, 10);
            for (n = 0; n < PHASE_ITEMS; n++)
                offer(pick_request(), 8'($urandom_range(255)));
        end
        drain();
    endtask

    // The receiver holds off long enough for the encoder to stall its input.
    task automatic test_backpressure;
        int n;
        gap_max   = 0;
        rx_mode   = RX_RANDOM;
        stall_pct = 20;
        hold_req  = 1'b1;
        for (n = 0; n < 12; n++)
            offer((n % 4 == 3) ? REQ_GAP : REQ_BYTE, 8'($urandom_range(255)));
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_level_change();
        test_run_tables();
        test_random_traffic();
        test_backpressure();
        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tape_byte_pulse_encoder_unit test passed");
        else
            $display("tape_byte_pulse_encoder_unit test failed");
        $finish;
    end

endmodule
